>>> rtl/core/ofdm_cyclic_prefix_remover_core_macros.svh
// Assertion macros shared by the cyclic prefix remover RTL.
`ifndef OFDM_CYCLIC_PREFIX_REMOVER_CORE_MACROS_SVH
`define OFDM_CYCLIC_PREFIX_REMOVER_CORE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define OCPR_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define OCPR_ASSERT_IMPLY(label, clk, rst_n, cause, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (expr)) \
        else $error(msg);

`endif

>>> rtl/core/ocpr_pkg.sv
`default_nettype none

package ocpr_pkg;

    // Field widths of the stream beats.
    localparam int SAMPLE_W   = 16;
    localparam int SLOT_NUM_W = 4;
    localparam int GROUP_W    = 2;
    localparam int INDEX_W    = 7;

    // Packed widths of the stream ports.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 8;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int FFT_LEN_W = 12;
    localparam logic PADDR_REG_FFT_LEN = 1'b0;

    // Frame structure.
    localparam int SLOTS         = 10;
    localparam int SYMBOLS       = 7;
    localparam int CP_SHORT_NUM  = 144;
    localparam int CP_LONG_NUM   = 160;
    localparam int FFT_LEN_REF   = 2048;
    localparam int CP_DEN_SHIFT  = 11;
    localparam int FFT_LEN_MIN   = 128;
    localparam int FFT_LEN_RESET = 2048;
    localparam int MAX_FFT_LEN_DEFAULT = 2048;

    // Cell group id code that carries no id.
    localparam logic [GROUP_W-1:0] GROUP_NONE = 2'd3;

endpackage

`default_nettype wire

>>> rtl/core/ofdm_cyclic_prefix_remover_core.sv
// Channel  | Direction | Signals                       | Beat contents
// ---------+-----------+-------------------------------+---------------------------------
// s_*      | in        | s_tvalid s_tready s_tdata/user | one baseband sample and its marks
// m_*      | out       | m_tvalid m_tready m_tdata/user | one useful sample with its tags
// APB      | in        | psel penable pwrite paddr ...  | fft_len at byte address 0
//
// One sample is taken per clock while m_tready does not hold the output; the work is one
// pass from the input register to the output register, from which a useful sample leaves.
// Prefix samples produce no output beat. The lengths used per sample are derived once
// when fft_len is written, so a sample right after a write uses the new lengths.
// rst_n clears all tracking state and loads fft_len = 2048. A stall on m_tready
// backs up through the one-entry input register to s_tready in the same cycle.
`default_nettype none
`include "ofdm_cyclic_prefix_remover_core_macros.svh"

module ofdm_cyclic_prefix_remover_core #(
    parameter int MAX_FFT_LEN = ocpr_pkg::MAX_FFT_LEN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [15:0] sample_i, [31:16] sample_q
    input  logic [ocpr_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] slot_mark_valid, [4:1] slot_mark_number, [5] id_mark_valid, [7:6] id_mark_value
    input  logic [ocpr_pkg::S_TUSER_W-1:0]  s_tuser,
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [15:0] out_i, [31:16] out_q, [38:32] symbol_index, [40:39] cell_group, rest zero
    output logic [ocpr_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] symbol_first, [1] half_frame_first
    output logic [ocpr_pkg::M_TUSER_W-1:0]  m_tuser,
    // symbol_last
    output logic                            m_tlast,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ocpr_pkg::PADDR_W-1:0]    paddr,
    input  logic [ocpr_pkg::PDATA_W-1:0]    pwdata,
    output logic [ocpr_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready
);

    localparam int CPS_MAX = ocpr_pkg::CP_SHORT_NUM * MAX_FFT_LEN / ocpr_pkg::FFT_LEN_REF;
    localparam int CPL_MAX = ocpr_pkg::CP_LONG_NUM * MAX_FFT_LEN / ocpr_pkg::FFT_LEN_REF;
    localparam int SL_MAX  = ocpr_pkg::SYMBOLS * MAX_FFT_LEN
                           + (ocpr_pkg::SYMBOLS - 1) * CPS_MAX + CPL_MAX;
    localparam int N_W     = $clog2(MAX_FFT_LEN + 1);
    localparam int CP_W    = $clog2(CPL_MAX + 1);
    localparam int SL_W    = $clog2(SL_MAX + 1);
    localparam int HF_W    = $clog2(ocpr_pkg::SLOTS * SL_MAX + 1);
    localparam int CNT_W   = $clog2(CPL_MAX + MAX_FFT_LEN + 1);
    localparam int PROD_W  = ocpr_pkg::FFT_LEN_W + 8;
    localparam int SW      = ocpr_pkg::SAMPLE_W;
    localparam int NB      = ocpr_pkg::SYMBOLS - 1;
    localparam int SLOT_W  = ocpr_pkg::SLOT_NUM_W;
    localparam int IDX_W   = ocpr_pkg::INDEX_W;
    localparam int GRP_W   = ocpr_pkg::GROUP_W;

    // Lengths derived from fft_len.
    typedef struct packed {
        logic [N_W-1:0]         n;
        logic [CP_W-1:0]        cps;
        logic [CP_W-1:0]        cpl;
        logic [SL_W-1:0]        sl;
        logic [HF_W-1:0]        hf;
        logic [NB-1:0][SL_W-1:0] bnd;
    } lengths_t;

    function automatic lengths_t derive(input logic [ocpr_pkg::FFT_LEN_W-1:0] len);
        logic [ocpr_pkg::FFT_LEN_W-1:0] c;
        logic [PROD_W-1:0]              ps;
        logic [PROD_W-1:0]              pl;
        lengths_t                       d;
        c = len;
        if (len < ocpr_pkg::FFT_LEN_W'(ocpr_pkg::FFT_LEN_MIN))
        begin
            c = ocpr_pkg::FFT_LEN_W'(ocpr_pkg::FFT_LEN_MIN);
        end
        else if (len > ocpr_pkg::FFT_LEN_W'(MAX_FFT_LEN))
        begin
            c = ocpr_pkg::FFT_LEN_W'(MAX_FFT_LEN);
        end
        d.n   = N_W'(c);
        ps    = PROD_W'(c) * PROD_W'(ocpr_pkg::CP_SHORT_NUM);
        pl    = PROD_W'(c) * PROD_W'(ocpr_pkg::CP_LONG_NUM);
        d.cps = CP_W'(ps >> ocpr_pkg::CP_DEN_SHIFT);
        d.cpl = CP_W'(pl >> ocpr_pkg::CP_DEN_SHIFT);
        d.sl  = SL_W'(d.n) * SL_W'(ocpr_pkg::SYMBOLS)
              + SL_W'(d.cps) * SL_W'(ocpr_pkg::SYMBOLS - 1) + SL_W'(d.cpl);
        d.hf  = HF_W'(d.sl) * HF_W'(ocpr_pkg::SLOTS);
        for (int k = 0; k < NB; k++)
        begin
            d.bnd[k] = SL_W'(d.n) + SL_W'(d.cpl) + SL_W'(k) * (SL_W'(d.n) + SL_W'(d.cps));
        end
        return d;
    endfunction

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    logic                           cfg_write;
    logic [ocpr_pkg::FFT_LEN_W-1:0] fft_len_reg;
    lengths_t                       len_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == ocpr_pkg::PADDR_REG_FFT_LEN);
    assign prdata    = (paddr[2] == ocpr_pkg::PADDR_REG_FFT_LEN)
                     ? ocpr_pkg::PDATA_W'(fft_len_reg) : '0;

    // The register and its derived lengths load together.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fft_len_reg <= ocpr_pkg::FFT_LEN_W'(ocpr_pkg::FFT_LEN_RESET);
            len_reg     <= derive(ocpr_pkg::FFT_LEN_W'(ocpr_pkg::FFT_LEN_RESET));
        end
        else if (cfg_write)
        begin
            fft_len_reg <= pwdata[ocpr_pkg::FFT_LEN_W-1:0];
            len_reg     <= derive(pwdata[ocpr_pkg::FFT_LEN_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Input register and handshake.
    // ------------------------------------------------------------------
    logic                           in_valid_reg;
    logic [ocpr_pkg::S_TDATA_W-1:0] in_data_reg;
    logic [ocpr_pkg::S_TUSER_W-1:0] in_user_reg;
    logic                           out_valid_reg;
    logic                           advance;
    logic                           s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    // Unpack the held beat.
    logic                   slot_mark_valid;
    logic [SLOT_W-1:0]      slot_mark_number;
    logic                   id_mark_valid;
    logic [GRP_W-1:0]       id_mark_value;

    assign slot_mark_valid  = in_user_reg[0];
    assign slot_mark_number = in_user_reg[4:1];
    assign id_mark_valid    = in_user_reg[5];
    assign id_mark_value    = in_user_reg[7:6];

    // ------------------------------------------------------------------
    // Half frame tracking.
    // ------------------------------------------------------------------
    logic [HF_W-1:0]    pos_reg, pos_next;
    logic [SL_W-1:0]    pos_slot_reg, pos_slot_next;
    logic [HF_W-1:0]    hf_origin_reg, hf_origin_next;
    logic [SL_W-1:0]    slot_origin_reg, slot_origin_next;
    logic               id_seen_reg, id_seen_next;
    logic [GRP_W-1:0]   group_reg, group_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [2:0]         sym_reg, sym_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               active_reg, active_next;

    logic               id_apply;
    logic               mark;
    logic [HF_W-1:0]    mark_off;
    logic [HF_W:0]      org_sum;
    logic [SL_W-1:0]    so;
    logic [SL_W-1:0]    r;
    logic               hf_hit;
    logic               sym_hit;
    logic               start;
    logic               active_now;
    logic [CNT_W-1:0]   c;
    logic [CP_W-1:0]    cp;
    logic               emit;
    logic               last;
    logic [IDX_W-1:0]   idx;
    logic               pos_wrap;

    always_comb
    begin
        id_apply = id_mark_valid && (id_mark_value != ocpr_pkg::GROUP_NONE);
        id_seen_next = id_seen_reg || id_apply;
        group_next   = id_apply ? id_mark_value : group_reg;

        // A slot mark fixes the half frame origin; the slot origin is p mod L.
        mark     = slot_mark_valid && (slot_mark_number <= SLOT_W'(ocpr_pkg::SLOTS - 1));
        mark_off = HF_W'(len_reg.sl)
                 * HF_W'(SLOT_W'(ocpr_pkg::SLOTS) - slot_mark_number);
        org_sum  = (HF_W + 1)'(pos_reg) + (HF_W + 1)'(mark_off);
        so       = mark ? pos_slot_reg : slot_origin_reg;
        r        = (pos_slot_reg >= so) ? pos_slot_reg - so
                                        : pos_slot_reg + len_reg.sl - so;

        // The new origin falls on this sample only for a mark of slot zero.
        hf_hit = mark ? (slot_mark_number == '0) : (pos_reg == hf_origin_reg);
        sym_hit = 1'b0;
        for (int k = 0; k < NB; k++)
        begin
            if (r == len_reg.bnd[k])
            begin
                sym_hit = 1'b1;
            end
        end

        hf_origin_next   = hf_origin_reg;
        slot_origin_next = slot_origin_reg;
        slot_next        = slot_reg;
        sym_next         = sym_reg;
        cnt_next         = cnt_reg;
        active_next      = active_reg;
        start            = 1'b0;
        emit             = 1'b0;
        last             = 1'b0;
        c                = cnt_reg;
        cp               = len_reg.cpl;
        active_now       = 1'b0;

        if (id_seen_next)
        begin
            if (mark)
            begin
                hf_origin_next   = (org_sum >= (HF_W + 1)'(len_reg.hf))
                                 ? HF_W'(org_sum - (HF_W + 1)'(len_reg.hf))
                                 : HF_W'(org_sum);
                slot_origin_next = pos_slot_reg;
            end
            priority if (hf_hit)
            begin
                slot_next = '0;
                sym_next  = '0;
                start     = 1'b1;
            end
            else if (r == '0)
            begin
                slot_next = (slot_reg == SLOT_W'(ocpr_pkg::SLOTS - 1)) ? '0 : slot_reg + 1'b1;
                sym_next  = '0;
                start     = 1'b1;
            end
            else if (sym_hit)
            begin
                sym_next  = (sym_reg == 3'(ocpr_pkg::SYMBOLS - 1)) ? '0 : sym_reg + 1'b1;
                start     = 1'b1;
            end
            else
            begin
                start     = 1'b0;
            end

            // The first symbol of a slot carries the long prefix.
            cp         = (sym_next == '0) ? len_reg.cpl : len_reg.cps;
            active_now = start || active_reg;
            c          = start ? '0 : cnt_reg;
            if (active_now)
            begin
                emit        = c >= CNT_W'(cp);
                last        = c == CNT_W'(cp) + CNT_W'(len_reg.n) - 1'b1;
                active_next = !(emit && last);
                cnt_next    = c + 1'b1;
            end
        end

        // Position in the half frame and in the slot advance on every sample.
        pos_wrap      = (HF_W + 1)'(pos_reg) + 1'b1 >= (HF_W + 1)'(len_reg.hf);
        pos_next      = pos_wrap ? '0 : pos_reg + 1'b1;
        pos_slot_next = (pos_wrap || (pos_slot_reg + 1'b1 >= len_reg.sl))
                      ? '0 : pos_slot_reg + 1'b1;
    end

    assign idx = IDX_W'(slot_next) * IDX_W'(ocpr_pkg::SYMBOLS) + IDX_W'(sym_next);

    // Tracking state: cleared by a write of fft_len, the id is kept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            pos_slot_reg    <= '0;
            hf_origin_reg   <= '0;
            slot_origin_reg <= '0;
            id_seen_reg     <= 1'b0;
            group_reg       <= '0;
            slot_reg        <= '0;
            sym_reg         <= '0;
            cnt_reg         <= '0;
            active_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            pos_reg         <= '0;
            pos_slot_reg    <= '0;
            hf_origin_reg   <= '0;
            slot_origin_reg <= '0;
            slot_reg        <= '0;
            sym_reg         <= '0;
            cnt_reg         <= '0;
            active_reg      <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg         <= pos_next;
            pos_slot_reg    <= pos_slot_next;
            hf_origin_reg   <= hf_origin_next;
            slot_origin_reg <= slot_origin_next;
            id_seen_reg     <= id_seen_next;
            group_reg       <= group_next;
            slot_reg        <= slot_next;
            sym_reg         <= sym_next;
            cnt_reg         <= cnt_next;
            active_reg      <= active_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic signed [SW-1:0]   out_i_reg;
    logic signed [SW-1:0]   out_q_reg;
    logic [IDX_W-1:0]       index_reg;
    logic                   first_reg;
    logic                   last_reg;
    logic                   hf_first_reg;
    logic [GRP_W-1:0]       cell_group_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_i_reg      <= in_data_reg[SW-1:0];
            out_q_reg      <= in_data_reg[2*SW-1:SW];
            index_reg      <= idx;
            first_reg      <= (c == CNT_W'(cp));
            last_reg       <= last;
            hf_first_reg   <= (idx == '0);
            cell_group_reg <= group_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ocpr_pkg::M_TDATA_W'({cell_group_reg, index_reg, out_q_reg, out_i_reg});
    assign m_tuser  = {hf_first_reg, first_reg};
    assign m_tlast  = last_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `OCPR_ASSERT_ALWAYS(a_pos_in_half_frame, clk, rst_n, pos_reg < len_reg.hf, "position beyond half frame")
    `OCPR_ASSERT_ALWAYS(a_pos_in_slot, clk, rst_n, pos_slot_reg < len_reg.sl, "slot offset beyond slot")
    `OCPR_ASSERT_IMPLY(a_slot_aligned, clk, rst_n, pos_reg == '0, pos_slot_reg == '0, "slot offset not aligned to half frame")
    `OCPR_ASSERT_IMPLY(a_active_needs_id, clk, rst_n, active_reg, id_seen_reg, "symbol active before any id")
    `OCPR_ASSERT_IMPLY(a_index_range, clk, rst_n, out_valid_reg, index_reg <= IDX_W'(ocpr_pkg::SLOTS * ocpr_pkg::SYMBOLS - 1), "symbol index out of range")

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ocpr_pkg::PADDR_W-1:0] FFT_LEN_ADDR =
        ocpr_pkg::PADDR_W'(ocpr_pkg::PADDR_REG_FFT_LEN);

    // Bit positions of the output tdata fields above the two sample parts.
    localparam int IDX_LSB = 2 * ocpr_pkg::SAMPLE_W;
    localparam int GRP_LSB = IDX_LSB + ocpr_pkg::INDEX_W;
    localparam int PAD_LSB = GRP_LSB + ocpr_pkg::GROUP_W;

    // Samples between slot marks in the half frame walk.
    localparam int MARK_GAP = 14;

    typedef struct {
        logic [ocpr_pkg::SAMPLE_W-1:0]   i;
        logic [ocpr_pkg::SAMPLE_W-1:0]   q;
        logic                            slot_valid;
        logic [ocpr_pkg::SLOT_NUM_W-1:0] slot_number;
        logic                            id_valid;
        logic [ocpr_pkg::GROUP_W-1:0]    id_value;
    } sample_t;

    typedef struct {
        logic [ocpr_pkg::SAMPLE_W-1:0] i;
        logic [ocpr_pkg::SAMPLE_W-1:0] q;
        logic [ocpr_pkg::INDEX_W-1:0]  index;
        logic                          first;
        logic                          last;
        logic                          hf_first;
        logic [ocpr_pkg::GROUP_W-1:0]  grp;
    } useful_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ocpr_pkg::S_TDATA_W-1:0] s_tdata;
    logic [ocpr_pkg::S_TUSER_W-1:0] s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [ocpr_pkg::M_TDATA_W-1:0] m_tdata;
    logic [ocpr_pkg::M_TUSER_W-1:0] m_tuser;
    logic                           m_tlast;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ocpr_pkg::PADDR_W-1:0]   paddr;
    logic [ocpr_pkg::PDATA_W-1:0]   pwdata;
    logic [ocpr_pkg::PDATA_W-1:0]   prdata;
    logic                           pready;

    // Predicted framing state, kept in step with every accepted input beat.
    logic [ocpr_pkg::FFT_LEN_W-1:0] fft_len_reg;
    int unsigned                    frame_pos;
    int unsigned                    frame_origin;
    int unsigned                    slot_base;
    logic                           id_known;
    logic [ocpr_pkg::GROUP_W-1:0]   cur_group;
    int unsigned                    slot_ctr;
    int unsigned                    sym_num;
    logic [ocpr_pkg::FFT_LEN_W-1:0] sym_offset;
    logic                           sym_open;

    useful_t useful_q[$];
    int      fail_count = 0;
    int      beat_count = 0;
    bit      src_idle_on = 1'b1;
    bit      snk_idle_on = 1'b1;

    ofdm_cyclic_prefix_remover_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // Lengths derived from the programmed FFT size.
    function automatic int unsigned clamp_len(logic [ocpr_pkg::FFT_LEN_W-1:0] v);
        if (v < ocpr_pkg::FFT_LEN_MIN)
            return ocpr_pkg::FFT_LEN_MIN;
        if (v > ocpr_pkg::MAX_FFT_LEN_DEFAULT)
            return ocpr_pkg::MAX_FFT_LEN_DEFAULT;
        return v;
    endfunction

    function automatic int unsigned short_prefix(int unsigned n);
        return ocpr_pkg::CP_SHORT_NUM * n / ocpr_pkg::FFT_LEN_REF;
    endfunction

    function automatic int unsigned long_prefix(int unsigned n);
        return ocpr_pkg::CP_LONG_NUM * n / ocpr_pkg::FFT_LEN_REF;
    endfunction

    function automatic int unsigned slot_length(int unsigned n);
        return ocpr_pkg::SYMBOLS * n + (ocpr_pkg::SYMBOLS - 1) * short_prefix(n)
             + long_prefix(n);
    endfunction

    function automatic void restart_tracking();
        frame_pos    = 0;
        frame_origin = 0;
        slot_base    = 0;
        slot_ctr     = 0;
        sym_num      = 0;
        sym_offset   = '0;
        sym_open     = 1'b0;
    endfunction

    // Advance the framing state by one sample and queue the useful beat it yields.
    task automatic predict_sample(input sample_t s);
        int unsigned n;
        int unsigned cps;
        int unsigned cpl;
        int unsigned sl;
        int unsigned hf;
        int unsigned r;
        int unsigned cp;
        int unsigned c;
        int unsigned idx;
        bit          start;
        useful_t     res;
        n   = clamp_len(fft_len_reg);
        cps = short_prefix(n);
        cpl = long_prefix(n);
        sl  = slot_length(n);
        hf  = ocpr_pkg::SLOTS * sl;

        if (s.id_valid && s.id_value != ocpr_pkg::GROUP_NONE) begin
            cur_group = s.id_value;
            id_known  = 1'b1;
        end

        if (id_known) begin
            // A valid slot mark moves the half frame origin.
            if (s.slot_valid && s.slot_number < ocpr_pkg::SLOTS) begin
                frame_origin = (frame_pos + sl * (ocpr_pkg::SLOTS - s.slot_number)) % hf;
                slot_base    = frame_origin % sl;
            end
            r     = (frame_pos % sl + sl - slot_base) % sl;
            start = 1'b0;
            if (frame_pos == frame_origin) begin
                slot_ctr = 0;
                sym_num  = 0;
                start    = 1'b1;
            end else if (r == 0) begin
                slot_ctr = (slot_ctr + 1) % ocpr_pkg::SLOTS;
                sym_num  = 0;
                start    = 1'b1;
            end else if (r >= n + cpl && (r - n - cpl) % (n + cps) == 0
                         && (r - n - cpl) / (n + cps) < ocpr_pkg::SYMBOLS - 1) begin
                sym_num = (sym_num + 1) % ocpr_pkg::SYMBOLS;
                start   = 1'b1;
            end
            if (start) begin
                sym_open   = 1'b1;
                sym_offset = '0;
            end

            // Samples past the prefix are passed on until the symbol is complete.
            if (sym_open) begin
                cp = (sym_num == 0) ? cpl : cps;
                c  = sym_offset;
                if (c >= cp) begin
                    idx          = ocpr_pkg::SYMBOLS * slot_ctr + sym_num;
                    res.i        = s.i;
                    res.q        = s.q;
                    res.index    = ocpr_pkg::INDEX_W'(idx);
                    res.first    = (c == cp);
                    res.last     = (c == cp + n - 1);
                    res.hf_first = (idx == 0);
                    res.grp      = cur_group;
                    useful_q.push_back(res);
                    if (res.last)
                        sym_open = 1'b0;
                end
                sym_offset = ocpr_pkg::FFT_LEN_W'(c + 1);
            end
        end

        frame_pos = (frame_pos + 1 >= hf) ? 0 : frame_pos + 1;
    endtask

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected %0h, got %0h", name, expv, actv);
            fail_count++;
        end
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.i           = ocpr_pkg::SAMPLE_W'($urandom);
        s.q           = ocpr_pkg::SAMPLE_W'($urandom);
        s.slot_valid  = 1'b0;
        s.slot_number = ocpr_pkg::SLOT_NUM_W'($urandom);
        s.id_valid    = 1'b0;
        s.id_value    = ocpr_pkg::GROUP_W'($urandom);
        return s;
    endfunction

    function automatic void shuffle_idling();
        src_idle_on = ($urandom_range(0, 3) != 0);
        snk_idle_on = ($urandom_range(0, 3) != 0);
    endfunction

    // Offer one input beat after a random gap; called and returned at a falling edge.
    task automatic send_sample(input sample_t s);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {s.q, s.i};
        s_tuser  <= {s.id_value, s.id_valid, s.slot_number, s.slot_valid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_sample(s);
        @(negedge clk);
    endtask

    // Stop the input stream and let every due beat and any prefix samples drain.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (useful_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // One APB transfer, setup then access, followed by a return to idle.
    task automatic apb_transfer(input logic wr, input logic [ocpr_pkg::PDATA_W-1:0] wdata,
                                output logic [ocpr_pkg::PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= FFT_LEN_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        if (wr) begin
            fft_len_reg = wdata[ocpr_pkg::FFT_LEN_W-1:0];
            restart_tracking();
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Program the FFT size with random upper bits, then read it back.
    task automatic set_fft_len(input logic [ocpr_pkg::FFT_LEN_W-1:0] len);
        logic [ocpr_pkg::PDATA_W-1:0] wdata;
        logic [ocpr_pkg::PDATA_W-1:0] rd;
        settle();
        wdata                          = $urandom;
        wdata[ocpr_pkg::FFT_LEN_W-1:0] = len;
        apb_transfer(1'b1, wdata, rd);
        apb_transfer(1'b0, $urandom, rd);
        check_field("fft_len readback", fft_len_reg, rd);
    endtask

    // Reset value, samples before any id, an undersized FFT length, ignored marks
    // and a slot boundary that cuts a symbol short.
    task automatic test_directed_marks();
        sample_t                      s;
        logic [ocpr_pkg::PDATA_W-1:0] rd;
        int                           k;
        apb_transfer(1'b0, '0, rd);
        check_field("fft_len reset value", ocpr_pkg::FFT_LEN_RESET, rd);

        s             = random_sample();
        s.slot_valid  = 1'b1;
        s.slot_number = '0;
        send_sample(s);
        s             = random_sample();
        s.slot_valid  = 1'b1;
        s.slot_number = '0;
        s.id_valid    = 1'b1;
        s.id_value    = ocpr_pkg::GROUP_NONE;
        send_sample(s);

        set_fft_len('0);
        for (k = 0; k < 26; k++) begin
            s = random_sample();
            case ((k + 2) % 4)
                0: begin s.i = 16'h8000; s.q = 16'h7fff; end
                1: begin s.i = 16'h7fff; s.q = 16'h8000; end
                2: begin s.i = 16'h0000; s.q = 16'hffff; end
                default: begin s.i = 16'hffff; s.q = 16'h0000; end
            endcase
            case (k)
                0: begin
                    s.id_valid = 1'b1;
                    s.id_value = 2'd2;
                end
                11: begin
                    s.slot_valid  = 1'b1;
                    s.slot_number = 4'd12;
                    s.id_valid    = 1'b1;
                    s.id_value    = 2'd0;
                end
                12: begin
                    s.slot_valid  = 1'b1;
                    s.slot_number = 4'd4;
                end
                20: begin
                    s.id_valid = 1'b1;
                    s.id_value = 2'd1;
                end
                23: begin
                    s.id_valid = 1'b1;
                    s.id_value = ocpr_pkg::GROUP_NONE;
                end
                default: ;
            endcase
            send_sample(s);
        end
    endtask

    // A short burst at each of several FFT sizes, including both clamped ranges.
    task automatic test_fft_len_settings();
        logic [ocpr_pkg::FFT_LEN_W-1:0] lens[5];
        sample_t                        s;
        int unsigned                    count;
        int                             m;
        int                             j;
        lens[0] = 12'd127;
        lens[1] = 12'hfff;
        lens[2] = 12'd128;
        lens[3] = 12'd200;
        lens[4] = ocpr_pkg::FFT_LEN_W'($urandom_range(129, 400));
        for (m = 0; m < 5; m++) begin
            set_fft_len(lens[m]);
            shuffle_idling();
            count = long_prefix(clamp_len(lens[m])) + $urandom_range(4, 12);
            for (j = 0; j < count; j++) begin
                s = random_sample();
                if (j == 0) begin
                    s.slot_valid  = 1'b1;
                    s.slot_number = '0;
                end
                send_sample(s);
            end
        end
    endtask

    // Slot and id marks at random places, some in bursts that push the slot count,
    // over a run long enough to cross symbol boundaries.
    task automatic test_mark_noise();
        sample_t s;
        int      burst_left;
        int      j;
        burst_left = 0;
        set_fft_len(ocpr_pkg::FFT_LEN_W'($urandom_range(128, 136)));
        for (j = 0; j < 200; j++) begin
            if (j % 64 == 0)
                shuffle_idling();
            s = random_sample();
            if (burst_left > 0) begin
                s.slot_valid  = 1'b1;
                s.slot_number = ocpr_pkg::SLOT_NUM_W'($urandom_range(1, 9));
                burst_left--;
            end else if ($urandom_range(0, 149) == 0) begin
                s.slot_valid  = 1'b1;
                s.slot_number = ocpr_pkg::SLOT_NUM_W'($urandom_range(0, 15));
                burst_left    = $urandom_range(0, 11);
            end
            if ($urandom_range(0, 59) == 0) begin
                s.id_valid = 1'b1;
                s.id_value = ocpr_pkg::GROUP_W'($urandom_range(0, 3));
            end
            send_sample(s);
        end
    endtask

    // Slot marks every few samples at the smallest size, so the slot count runs
    // through a whole half frame and wraps back to the first symbol.
    task automatic test_half_frame();
        sample_t s;
        int      j;
        set_fft_len(ocpr_pkg::FFT_LEN_W'(ocpr_pkg::FFT_LEN_MIN));
        for (j = 0; j < 12 * MARK_GAP; j++) begin
            if (j % 64 == 0)
                shuffle_idling();
            s = random_sample();
            if (j % MARK_GAP == 0) begin
                s.slot_valid  = 1'b1;
                s.slot_number = (j == 0) ? '0
                              : ocpr_pkg::SLOT_NUM_W'($urandom_range(1, 9));
            end
            if ($urandom_range(0, 99) == 0) begin
                s.id_valid = 1'b1;
                s.id_value = ocpr_pkg::GROUP_W'($urandom_range(0, 3));
            end
            send_sample(s);
        end
    endtask

    // Output ready: after each taken beat, hold off for a random number of cycles.
    int stall_left = 0;
    int beats_seen = 0;
    always @(negedge clk) begin
        if (beat_count != beats_seen) begin
            beats_seen = beat_count;
            stall_left = snk_idle_on ? $urandom_range(0, 6) : 0;
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest predicted useful sample.
    useful_t due;
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            beat_count++;
            if (useful_q.size() == 0) begin
                $error("output beat with no useful sample due");
                fail_count++;
            end else begin
                due = useful_q.pop_front();
                check_field("out_i", due.i, m_tdata[ocpr_pkg::SAMPLE_W-1:0]);
                check_field("out_q", due.q, m_tdata[IDX_LSB-1:ocpr_pkg::SAMPLE_W]);
                check_field("symbol_index", due.index, m_tdata[GRP_LSB-1:IDX_LSB]);
                check_field("cell_group", due.grp, m_tdata[PAD_LSB-1:GRP_LSB]);
                check_field("tdata padding", '0, m_tdata[ocpr_pkg::M_TDATA_W-1:PAD_LSB]);
                check_field("symbol_first", due.first, m_tuser[0]);
                check_field("half_frame_first", due.hf_first, m_tuser[1]);
                check_field("symbol_last", due.last, m_tlast);
            end
        end
    end

    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        fft_len_reg = ocpr_pkg::FFT_LEN_W'(ocpr_pkg::FFT_LEN_RESET);
        id_known    = 1'b0;
        cur_group   = '0;
        restart_tracking();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_marks();
        test_fft_len_settings();
        test_mark_noise();
        test_half_frame();
        settle();

        if (fail_count == 0)
            $display("ofdm_cyclic_prefix_remover_core regression: pass");
        else
            $display("ofdm_cyclic_prefix_remover_core regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("ofdm_cyclic_prefix_remover_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl/core
rtl/core/ocpr_pkg.sv
rtl/core/ofdm_cyclic_prefix_remover_core.sv
sim/tb.sv
